FILE: rtl/core/pses_pkg.sv
// Shared constants, codes, types and helpers for the prefix expression evaluator
`default_nettype none

package pses_pkg;

    // Data path and stack sizing
    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int DIV_CNT_W       = $clog2(DATA_W + 1);

    // Field widths
    localparam int SEL_W  = 3;
    localparam int OP_W   = 3;
    localparam int STS_W  = 3;
    localparam int CIDX_W = 2;

    // Variable register reset values
    localparam logic [DATA_W-1:0] VALUE_A_RST = DATA_W'(2);
    localparam logic [DATA_W-1:0] VALUE_B_RST = DATA_W'(4);
    localparam logic [DATA_W-1:0] VALUE_C_RST = DATA_W'(6);
    localparam logic [DATA_W-1:0] VALUE_D_RST = DATA_W'(1);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_VALUE_A = 2'd0;
    localparam logic [CIDX_W-1:0] REG_VALUE_B = 2'd1;
    localparam logic [CIDX_W-1:0] REG_VALUE_C = 2'd2;
    localparam logic [CIDX_W-1:0] REG_VALUE_D = 2'd3;

    // Token kinds
    localparam logic KIND_OPERAND  = 1'b0;
    localparam logic KIND_OPERATOR = 1'b1;

    // Variable selects
    localparam logic [SEL_W-1:0] VAR_A = 3'd0;
    localparam logic [SEL_W-1:0] VAR_B = 3'd1;
    localparam logic [SEL_W-1:0] VAR_C = 3'd2;
    localparam logic [SEL_W-1:0] VAR_D = 3'd3;

    // Operator codes; codes above OP_XOR pop only
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_XOR = 3'd4;

    // Status codes
    localparam logic [STS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STS_W-1:0] ST_UNDER = 3'd1;
    localparam logic [STS_W-1:0] ST_OVER  = 3'd2;
    localparam logic [STS_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [STS_W-1:0] ST_EMPTY = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic push_var;
        logic pop;
        logic take_left;
        logic exec;
        logic push_res;
        logic fin_read;
        logic emit;
    } pses_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic tok_last;
        logic need_div;
        logic div_done;
        logic out_free;
    } pses_sts_t;

    // Keep the first error of an expression
    function automatic logic [STS_W-1:0] sticky_flag(input logic [STS_W-1:0] cur,
                                                     input logic [STS_W-1:0] code);
        sticky_flag = (cur == ST_OK) ? code : cur;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pses_div.sv
// Iterative signed truncating divider, one quotient bit per cycle
`default_nettype none

module pses_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pses_pkg::DATA_W-1:0]  dividend,
    input  wire logic [pses_pkg::DATA_W-1:0]  divisor,
    output logic                              done,
    output logic [pses_pkg::DATA_W-1:0]       quotient
);

    localparam int W = pses_pkg::DATA_W;

    logic                             busy_reg;
    logic                             done_reg;
    logic [pses_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [W-1:0]                     quo_reg;
    logic [W-1:0]                     rem_reg;
    logic [W-1:0]                     dm_reg;
    logic                             neg_reg;
    logic [W:0]                       shifted;
    logic                             fits;

    // Trial subtract of the shifted remainder
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign fits    = (shifted >= {1'b0, dm_reg});

    // Control: count iterations, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= pses_pkg::DIV_CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - pses_pkg::DIV_CNT_W'(1);
                if (cnt_reg == pses_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitudes, then shift in one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            dm_reg  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? W'(shifted - {1'b0, dm_reg}) : shifted[W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pses_dp.sv
// Datapath: variable registers, operand stack memory, ALU, divider and output register
`default_nettype none

module pses_dp #(
    parameter int STACK_DEPTH = pses_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [pses_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [pses_pkg::DATA_W-1:0]   cfg_data,
    input  wire logic                          in_accept,
    input  wire logic [pses_pkg::SEL_W-1:0]    variable_select,
    input  wire logic [pses_pkg::OP_W-1:0]     command,
    input  wire logic                          last_token,
    input  wire pses_pkg::pses_cmd_t           ctl,
    output pses_pkg::pses_sts_t                sts,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [pses_pkg::DATA_W-1:0]        result_word,
    output logic [pses_pkg::STS_W-1:0]         status_code
);

    localparam int W    = pses_pkg::DATA_W;
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    // Variable registers
    logic [W-1:0] value_a_reg, value_b_reg, value_c_reg, value_d_reg;

    // Latched token
    logic [pses_pkg::SEL_W-1:0] sel_reg;
    logic [pses_pkg::OP_W-1:0]  op_reg;
    logic                       last_reg;

    // Stack state
    logic [SP_W-1:0]            sp_reg, sp_next, sp_dec;
    logic [pses_pkg::STS_W-1:0] err_reg, err_next;
    logic                       pop_ok_reg, pop_ok_next;
    logic                       fin_has_reg, fin_has_next;
    logic                       sp_in_range;

    // Memory ports
    logic [W-1:0]  stack_mem [STACK_DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [W-1:0]  mem_wdata;
    logic [W-1:0]  rd_data_reg;

    // ALU
    logic [W-1:0] left_reg, right_val, res_reg, var_val, prod;
    logic         push_en;
    logic [W-1:0] push_data;
    logic         div_start, div_done;
    logic [W-1:0] div_quo;

    // Output register
    logic                       out_valid_reg;
    logic [W-1:0]               result_reg;
    logic [pses_pkg::STS_W-1:0] status_reg;
    logic                       out_free, out_load;

    assign sp_dec      = sp_reg - SP_W'(1);
    assign sp_in_range = (sp_reg != '0) && (sp_reg <= SP_W'(STACK_DEPTH));
    assign right_val   = pop_ok_reg ? rd_data_reg : '0;
    assign prod        = left_reg * right_val;
    assign out_free    = !out_valid_reg || out_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_a_reg <= pses_pkg::VALUE_A_RST;
            value_b_reg <= pses_pkg::VALUE_B_RST;
            value_c_reg <= pses_pkg::VALUE_C_RST;
            value_d_reg <= pses_pkg::VALUE_D_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pses_pkg::REG_VALUE_A: value_a_reg <= cfg_data;
                pses_pkg::REG_VALUE_B: value_b_reg <= cfg_data;
                pses_pkg::REG_VALUE_C: value_c_reg <= cfg_data;
                pses_pkg::REG_VALUE_D: value_d_reg <= cfg_data;
                default:               value_a_reg <= value_a_reg;
            endcase
        end
    end

    // Select the variable value; other letters push zero
    always_comb
    begin
        unique case (sel_reg)
            pses_pkg::VAR_A: var_val = value_a_reg;
            pses_pkg::VAR_B: var_val = value_b_reg;
            pses_pkg::VAR_C: var_val = value_c_reg;
            pses_pkg::VAR_D: var_val = value_d_reg;
            default:         var_val = '0;
        endcase
    end

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sel_reg  <= variable_select;
            op_reg   <= command;
            last_reg <= last_token;
        end
    end

    // Stack control: push, pop, final read, clear on emit
    always_comb
    begin
        sp_next      = sp_reg;
        err_next     = err_reg;
        pop_ok_next  = pop_ok_reg;
        fin_has_next = fin_has_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        wr_addr      = sp_reg[AW-1:0];
        rd_addr      = sp_dec[AW-1:0];
        out_load     = 1'b0;
        push_en      = ctl.push_var || (ctl.push_res && (op_reg <= pses_pkg::OP_XOR));
        push_data    = ctl.push_var ? var_val : res_reg;
        mem_wdata    = push_data;

        if (push_en)
        begin
            if (sp_reg >= SP_W'(STACK_DEPTH))
            begin
                err_next = pses_pkg::sticky_flag(err_reg, pses_pkg::ST_OVER);
            end
            else
            begin
                mem_we  = 1'b1;
                sp_next = sp_reg + SP_W'(1);
            end
        end

        if (ctl.pop)
        begin
            if (sp_in_range)
            begin
                mem_re      = 1'b1;
                sp_next     = sp_dec;
                pop_ok_next = 1'b1;
            end
            else
            begin
                pop_ok_next = 1'b0;
                err_next    = pses_pkg::sticky_flag(err_reg, pses_pkg::ST_UNDER);
            end
        end

        if (ctl.exec && (op_reg == pses_pkg::OP_DIV) && (right_val == '0))
        begin
            err_next = pses_pkg::sticky_flag(err_reg, pses_pkg::ST_DIVZ);
        end

        if (ctl.fin_read)
        begin
            mem_re       = sp_in_range;
            fin_has_next = sp_in_range;
        end

        if (ctl.emit && out_free)
        begin
            out_load = 1'b1;
            sp_next  = '0;
            err_next = pses_pkg::ST_OK;
        end
    end

    // Hold stack pointer and sticky status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            err_reg     <= pses_pkg::ST_OK;
            pop_ok_reg  <= 1'b0;
            fin_has_reg <= 1'b0;
        end
        else
        begin
            sp_reg      <= sp_next;
            err_reg     <= err_next;
            pop_ok_reg  <= pop_ok_next;
            fin_has_reg <= fin_has_next;
        end
    end

    // Operand stack memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Capture left operand and compute the result
    always_ff @(posedge clk)
    begin
        if (ctl.take_left)
        begin
            left_reg <= right_val;
        end
        if (ctl.exec)
        begin
            unique case (op_reg)
                pses_pkg::OP_ADD: res_reg <= left_reg + right_val;
                pses_pkg::OP_SUB: res_reg <= left_reg - right_val;
                pses_pkg::OP_MUL: res_reg <= prod;
                pses_pkg::OP_XOR: res_reg <= left_reg ^ right_val;
                default:          res_reg <= '0;
            endcase
        end
        else if (div_done)
        begin
            res_reg <= div_quo;
        end
    end

    assign div_start = ctl.exec && (op_reg == pses_pkg::OP_DIV) && (right_val != '0);

    pses_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_reg),
        .divisor  (right_val),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= fin_has_reg ? rd_data_reg : '0;
            status_reg <= (fin_has_reg || (err_reg != pses_pkg::ST_OK)) ?
                          err_reg : pses_pkg::ST_EMPTY;
        end
    end

    assign sts.tok_last = last_reg;
    assign sts.need_div = (op_reg == pses_pkg::OP_DIV) && (right_val != '0);
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

    assign out_valid   = out_valid_reg;
    assign result_word = result_reg;
    assign status_code = status_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != pses_pkg::ST_OK && !out_load) |=> (err_reg == $past(err_reg)))
        else $error("sticky status changed before the expression ended");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sp_reg == '0 && err_reg == pses_pkg::ST_OK && out_valid_reg))
        else $error("stack not cleared after result was loaded");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pses_ctrl.sv
// Controller state machine that sequences each item through the datapath
`default_nettype none

module pses_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 token_kind,
    output logic                      in_ready,
    input  wire pses_pkg::pses_sts_t  sts,
    output pses_pkg::pses_cmd_t       ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_VAR,
        S_POP_L,
        S_POP_R,
        S_EXEC,
        S_DIV_WAIT,
        S_PUSH_RES,
        S_FIN_READ,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Advance through the steps of one item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= (token_kind == pses_pkg::KIND_OPERATOR) ?
                                     S_POP_L : S_PUSH_VAR;
                    end
                end
                S_PUSH_VAR: state_reg <= sts.tok_last ? S_FIN_READ : S_IDLE;
                S_POP_L:    state_reg <= S_POP_R;
                S_POP_R:    state_reg <= S_EXEC;
                S_EXEC:     state_reg <= sts.need_div ? S_DIV_WAIT : S_PUSH_RES;
                S_DIV_WAIT:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_PUSH_RES;
                    end
                end
                S_PUSH_RES: state_reg <= sts.tok_last ? S_FIN_READ : S_IDLE;
                S_FIN_READ: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    // Decode commands from the state
    assign in_ready      = (state_reg == S_IDLE);
    assign ctl.push_var  = (state_reg == S_PUSH_VAR);
    assign ctl.pop       = (state_reg == S_POP_L) || (state_reg == S_POP_R);
    assign ctl.take_left = (state_reg == S_POP_R);
    assign ctl.exec      = (state_reg == S_EXEC);
    assign ctl.push_res  = (state_reg == S_PUSH_RES);
    assign ctl.fin_read  = (state_reg == S_FIN_READ);
    assign ctl.emit      = (state_reg == S_EMIT);

endmodule

`default_nettype wire

FILE: rtl/core/prefix_expression_stack_evaluator_unit.sv
// Top level of the prefix expression stack evaluator
//
// Usage: tokens of a prefix expression, already reversed, enter one item at a
// time on the in_valid/in_ready channel. An operand pushes value_a..value_d
// (other letters push 0); an operator pops left then right and pushes the
// result unless its code is above xor. The item marked last_token produces
// one result (top of stack and status) on out_valid/out_ready, and the stack
// and status are cleared. Configuration: cfg_write with cfg_index selects
// value_a..value_d; writes take effect at once, with no read-back.
// Sequence: an operand is taken, then pushed; an operator is taken, pops
// left, pops right, executes and enters the push step; a divide by a
// nonzero divisor first waits for the bit-serial divider, which produces
// one quotient bit per cycle. The last item adds a top-of-stack read from
// the stack memory port, then the result sits in the output register.
// Reset clears the stack pointer and status, restores the variable defaults
// and leaves the output channel empty. If the receiver stalls, the next item
// is still taken; the block holds only when a second result would need the
// still-occupied output register.
`default_nettype none

module prefix_expression_stack_evaluator_unit #(
    parameter int STACK_DEPTH = pses_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [pses_pkg::CIDX_W-1:0]         cfg_index,
    input  wire logic [pses_pkg::DATA_W-1:0]         cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                token_kind,
    input  wire logic [pses_pkg::SEL_W-1:0]          variable_select,
    input  wire logic [pses_pkg::OP_W-1:0]           command,
    input  wire logic                                last_token,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [pses_pkg::DATA_W-1:0]       result_value,
    output logic [pses_pkg::STS_W-1:0]               status
);

    pses_pkg::pses_cmd_t         ctl;
    pses_pkg::pses_sts_t         sts;
    logic                        in_accept;
    logic [pses_pkg::DATA_W-1:0] result_word;

    assign in_accept    = in_valid && in_ready;
    assign result_value = $signed(result_word);

    pses_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .token_kind (token_kind),
        .in_ready   (in_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    pses_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_accept       (in_accept),
        .variable_select (variable_select),
        .command         (command),
        .last_token      (last_token),
        .ctl             (ctl),
        .sts             (sts),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .result_word     (result_word),
        .status_code     (status)
    );

endmodule

`default_nettype wire
